@@ rtl/core/bba_pkg.sv @@
package bba_pkg;

  localparam int unsigned MaxBlocks = 32;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned SizeW     = 24;
  localparam int unsigned CountW    = 6;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DivSteps  = AddrW;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);
  localparam int unsigned ProdW     = SizeW + IdxW;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_BLOCK_SIZE   = 2'd1,
    CFG_BLOCK_COUNT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] block_address;
    logic [IdxW-1:0]  block_index;
  } rsp_t;

  typedef struct packed {
    logic             start;
    logic [AddrW-1:0] dividend;
    logic [SizeW-1:0] divisor;
  } div_req_t;

endpackage

@@ rtl/core/bba_divider.sv @@
module bba_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bba_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [bba_pkg::AddrW-1:0] quot_o
);
  import bba_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [SizeW-1:0]   rem_q, rem_d;
  logic [SizeW-1:0]   dvs_q, dvs_d;
  logic [AddrW-1:0]   quot_q, quot_d;
  logic [SizeW:0]     trial;
  logic [SizeW+1:0]   diff;
  logic               ge;

  assign trial = {rem_q, quot_q[AddrW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[SizeW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivSteps);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quot_d = req_i.dividend;
    end else if (busy_q) begin
      rem_d  = ge ? diff[SizeW-1:0] : trial[SizeW-1:0];
      quot_d = {quot_q[AddrW-2:0], ge};
      cnt_d  = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with empty step count");

endmodule

@@ rtl/core/bitmap_block_allocator.sv @@
// Fixed-block pool allocator. An allocate transfer claims the lowest free block below
// block_count (capped at 32) and returns base_address + block_size * index; a free transfer
// divides (free_address - base_address) by block_size and releases that block. Status is
// 0 ok, 1 pool full, 2 invalid or unallocated free. One request is in progress at a time:
// an allocate goes straight to the result when the count is already full, otherwise it
// scans the bitmap one bit per cycle up to the index found, then multiplies and adds; a free
// runs the 32-step restoring divider, or skips it when block_size is zero. A finished result
// sits in the output register, so the next request is taken while it waits.
// Configuration writes leave the bitmap and count unchanged.
module bitmap_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bba_pkg::AddrW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bba_pkg::req_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bba_pkg::rsp_t               out_data_o
);
  import bba_pkg::*;

  state_e              state_q, state_d;
  logic [AddrW-1:0]    base_q;
  logic [SizeW-1:0]    bsize_q;
  logic [CountW-1:0]   bcount_q;
  logic [MaxBlocks-1:0] map_q, map_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [CountW-1:0]   idx_q, idx_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  rsp_t                res_q, res_d;
  rsp_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [CountW-1:0]   pool_n;
  logic                accept, alloc_full, scan_end, scan_hit, free_bad, out_free, bsize_zero;
  div_req_t            div_req;
  logic                div_done;
  logic [AddrW-1:0]    quot;

  assign pool_n     = (bcount_q > CountW'(MaxBlocks)) ? CountW'(MaxBlocks) : bcount_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign alloc_full = (count_q >= pool_n);
  assign bsize_zero = (bsize_q == '0);
  assign scan_end   = (idx_q >= pool_n);
  assign scan_hit   = !map_q[idx_q[IdxW-1:0]];
  assign free_bad   = (quot >= AddrW'(pool_n)) || !map_q[quot[IdxW-1:0]];
  assign out_free   = !out_valid_q || out_ready_i;

  assign div_req.start    = accept && (in_data_i.func == FUNC_FREE) && !bsize_zero;
  assign div_req.dividend = in_data_i.free_address - base_q;
  assign div_req.divisor  = bsize_q;

  bba_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      bsize_q  <= SizeW'(1);
      bcount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_ADDRESS: base_q   <= cfg_wdata_i;
        CFG_BLOCK_SIZE:   bsize_q  <= cfg_wdata_i[SizeW-1:0];
        CFG_BLOCK_COUNT:  bcount_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.func == FUNC_ALLOC) begin
            state_d = alloc_full ? S_DONE : S_SCAN;
          end else begin
            state_d = bsize_zero ? S_DONE : S_DIV;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_DONE;
        end else if (scan_hit) begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_ADD;
      S_ADD:  state_d = S_DONE;
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    map_d       = map_q;
    count_d     = count_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (accept) begin
          res_d.block_address = '0;
          res_d.block_index   = '0;
          res_d.status        = (in_data_i.func == FUNC_ALLOC) ? ST_FULL : ST_INVALID;
        end
      end
      S_SCAN: begin
        if (!scan_end && !scan_hit) begin
          idx_d = idx_q + CountW'(1);
        end
      end
      S_MUL: prod_d = ProdW'(bsize_q) * ProdW'(idx_q[IdxW-1:0]);
      S_ADD: begin
        res_d.status        = ST_OK;
        res_d.block_address = base_q + AddrW'(prod_q);
        res_d.block_index   = idx_q[IdxW-1:0];
        map_d[idx_q[IdxW-1:0]] = 1'b1;
        count_d = count_q + CountW'(1);
      end
      S_DIV: begin
        if (div_done && !free_bad) begin
          res_d.status      = ST_OK;
          res_d.block_index = quot[IdxW-1:0];
          map_d[quot[IdxW-1:0]] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CountW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      map_q       <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_q       <= map_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CountW'($countones(map_q))) else $error("used count differs from bitmap");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != ST_OK) |-> out_q.block_address == '0 &&
      out_q.block_index == '0) else $error("error result with non-zero payload");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE) else $error("accepted request dropped");

endmodule
